@@ sv/hdm_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdm_pkg
// Shared constants, tables and helpers for the haversine distance pipeline.
// ---------------------------------------------------------------------------
package hdm_pkg;

  // Angle input width: degrees, 21 fractional bits, signed
  localparam int ANG_W = 31;
  // CORDIC datapath widths
  localparam int X_W = 34;
  localparam int Z_W = 33;

  // Angle limits in degrees Q21
  localparam logic signed [31:0] FULL_TURN    = 32'sd754974720;
  localparam logic signed [31:0] HALF_TURN    = 32'sd377487360;
  localparam logic signed [31:0] QUARTER_TURN = 32'sd188743680;

  // pi * 2^60, and the degree-to-radian factor in Q39
  localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG2RAD_FULL = ((PI_Q60 / 64'd180) + 64'd1048576) >> 21;
  localparam logic [33:0] DEG2RAD_Q39  = DEG2RAD_FULL[33:0];

  // CORDIC start value (1/K in Q30) and unit limit
  localparam logic signed [X_W-1:0] INV_GAIN = 34'sd652032874;
  localparam logic signed [X_W-1:0] ONE_X    = 34'sd1073741824;

  // arctan(2^-i) in Q30, truncated
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // Radian angle (Q30) to miles (Q8): z * 12742000 / (1609 * 2^22), round half up
  localparam logic [23:0] MILES_K    = 24'd12742000;
  localparam logic [55:0] MILES_BIAS = 56'd1609 << 21;
  localparam logic [32:0] MILES_DIV  = 33'd1609;
  localparam logic [63:0] RECIP_FULL = (64'd1 << 42) / 64'd1609;
  localparam logic [31:0] MILES_RECIP = RECIP_FULL[31:0];

  localparam int DIST_W = 22;

  // Clamp a CORDIC coordinate to [-1, 1] in Q30
  function automatic logic signed [31:0] clamp_unit(input logic signed [X_W-1:0] v);
    logic signed [X_W-1:0] r;
    if (v > ONE_X) begin
      r = ONE_X;
    end else if (v < -ONE_X) begin
      r = -ONE_X;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

endpackage

@@ sv/hdm_sincos.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdm_sincos
// Pipelined sine/cosine: range reduction, fold, degree-to-radian scaling,
// then one rotation-mode CORDIC iteration per stage.
// ---------------------------------------------------------------------------
module hdm_sincos
  import hdm_pkg::*;
#(
  parameter int STAGES = 24
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [ANG_W-1:0] angle_i,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);

  // Stage A: reduce into [-180, 180)
  logic signed [31:0] ang_ext, red_d, red_q;

  always_comb begin
    ang_ext = {{(32-ANG_W){angle_i[ANG_W-1]}}, angle_i};
    if (ang_ext >= HALF_TURN) begin
      red_d = ang_ext - FULL_TURN;
    end else if (ang_ext < -HALF_TURN) begin
      red_d = ang_ext + FULL_TURN;
    end else begin
      red_d = ang_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) red_q <= red_d;
  end

  // Stage B: fold into [-90, 90], split sign and magnitude
  logic signed [31:0] fold;
  logic               flip_d, flip_b_q, neg_b_q;
  logic [31:0]        fmag;
  logic [27:0]        mag_q;

  always_comb begin
    flip_d = 1'b0;
    fold   = red_q;
    if (red_q > QUARTER_TURN) begin
      fold   = HALF_TURN - red_q;
      flip_d = 1'b1;
    end else if (red_q < -QUARTER_TURN) begin
      fold   = -HALF_TURN - red_q;
      flip_d = 1'b1;
    end
    fmag = fold[31] ? 32'(-fold) : 32'(fold);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q    <= fmag[27:0];
      neg_b_q  <= fold[31];
      flip_b_q <= flip_d;
    end
  end

  // Stage C: scale to radians
  logic [61:0] prod_q;
  logic        neg_c_q, flip_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= 62'(mag_q) * 62'(DEG2RAD_Q39);
      neg_c_q  <= neg_b_q;
      flip_c_q <= flip_b_q;
    end
  end

  // Stage D: round to Q30 and restore sign; CORDIC start vector
  logic [61:0] rnd;
  logic signed [Z_W-1:0] z0;

  always_comb begin
    rnd = prod_q + 62'd536870912;
    z0  = neg_c_q ? -$signed({1'b0, rnd[61:30]}) : $signed({1'b0, rnd[61:30]});
  end

  logic signed [X_W-1:0] x_q [STAGES+1];
  logic signed [X_W-1:0] y_q [STAGES+1];
  logic signed [Z_W-1:0] z_q [STAGES+1];
  logic                  f_q [STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= INV_GAIN;
      y_q[0] <= '0;
      z_q[0] <= z0;
      f_q[0] <= flip_c_q;
    end
  end

  // CORDIC rotation stages
  for (genvar g = 0; g < STAGES; g++) begin : g_rot
    localparam logic signed [Z_W-1:0] AT = Z_W'(ATAN_Q30[g]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[g] >= 0) begin
          x_q[g+1] <= x_q[g] - (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] + (x_q[g] >>> g);
          z_q[g+1] <= z_q[g] - AT;
        end else begin
          x_q[g+1] <= x_q[g] + (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] - (x_q[g] >>> g);
          z_q[g+1] <= z_q[g] + AT;
        end
        f_q[g+1] <= f_q[g];
      end
    end
  end

  // Stage E: clamp, undo fold on cosine
  logic signed [31:0] cx;
  assign cx = clamp_unit(x_q[STAGES]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= clamp_unit(y_q[STAGES]);
      cos_o <= f_q[STAGES] ? -cx : cx;
    end
  end

endmodule

@@ sv/hdm_hav.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdm_hav
// Haversine term a = u^2 + (cos1*cos2*v)*v in Q60, clamped to [0, 1],
// plus its complement 1 - a. Five register stages.
// ---------------------------------------------------------------------------
module hdm_hav
  import hdm_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] cos1_i,
  input  logic signed [31:0] cos2_i,
  input  logic signed [31:0] u_i,
  input  logic signed [31:0] v_i,
  output logic [60:0]        a_o,
  output logic [60:0]        b_o
);

  logic signed [63:0] p1, uu, p2, p3;
  logic signed [31:0] cc_q, cv_q, v1_q, v2_q;
  logic [60:0]        uu1_q, uu2_q, uu3_q, a_q;
  logic signed [61:0] t_q;
  logic signed [62:0] sum;

  assign p1 = cos1_i * cos2_i;
  assign uu = u_i * u_i;
  assign p2 = cc_q * v1_q;
  assign p3 = cv_q * v2_q;

  // Stages 1-3: product chain, u^2 rides along
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q  <= p1[61:30];
      uu1_q <= uu[60:0];
      v1_q  <= v_i;
      cv_q  <= p2[61:30];
      uu2_q <= uu1_q;
      v2_q  <= v1_q;
      t_q   <= p3[61:0];
      uu3_q <= uu2_q;
    end
  end

  // Stage 4: sum and clamp to [0, 2^60]
  assign sum = $signed({2'b00, uu3_q}) + 63'(t_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (sum < 0) begin
        a_q <= '0;
      end else if (sum > 63'sd1152921504606846976) begin
        a_q <= 61'd1152921504606846976;
      end else begin
        a_q <= sum[60:0];
      end
    end
  end

  // Stage 5: complement
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o <= a_q;
      b_o <= 61'd1152921504606846976 - a_q;
    end
  end

endmodule

@@ sv/hdm_isqrt.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdm_isqrt
// Pipelined integer square root of a Q60 value, one root bit per stage,
// 31 stages. Result is floor(sqrt(val)).
// ---------------------------------------------------------------------------
module hdm_isqrt
  import hdm_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [60:0] val_i,
  output logic [30:0] root_o
);

  logic [61:0] val_q  [31];
  logic [32:0] rem_q  [31];
  logic [30:0] root_q [31];

  for (genvar k = 0; k < 31; k++) begin : g_stage
    localparam int P = 30 - k;
    logic [61:0] val_in;
    logic [32:0] rem_in;
    logic [30:0] root_in;
    logic [34:0] cur, trial;

    if (k == 0) begin : g_first
      assign val_in  = {1'b0, val_i};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign val_in  = val_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign cur   = {rem_in, val_in[2*P+1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[k] <= val_in;
        if (cur >= trial) begin
          rem_q[k]  <= 33'(cur - trial);
          root_q[k] <= {root_in[29:0], 1'b1};
        end else begin
          rem_q[k]  <= cur[32:0];
          root_q[k] <= {root_in[29:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[30];

endmodule

@@ sv/hdm_asin.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdm_asin
// Vectoring-mode CORDIC on (x = cos, y = sin) giving the angle in Q30,
// negative results clamped to zero.
// ---------------------------------------------------------------------------
module hdm_asin
  import hdm_pkg::*;
#(
  parameter int STAGES = 24
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] w_i,
  input  logic [30:0] h_i,
  output logic [30:0] angle_o
);

  logic signed [X_W-1:0] x_q [STAGES+1];
  logic signed [X_W-1:0] y_q [STAGES+1];
  logic signed [Z_W-1:0] z_q [STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= $signed({3'b000, w_i});
      y_q[0] <= $signed({3'b000, h_i});
      z_q[0] <= '0;
    end
  end

  // Drive y toward zero, accumulate angle
  for (genvar g = 0; g < STAGES; g++) begin : g_vec
    localparam logic signed [Z_W-1:0] AT = Z_W'(ATAN_Q30[g]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[g] > 0) begin
          x_q[g+1] <= x_q[g] + (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] - (x_q[g] >>> g);
          z_q[g+1] <= z_q[g] + AT;
        end else begin
          x_q[g+1] <= x_q[g] - (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] + (x_q[g] >>> g);
          z_q[g+1] <= z_q[g] - AT;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) angle_o <= z_q[STAGES][Z_W-1] ? '0 : z_q[STAGES][30:0];
  end

endmodule

@@ sv/hdm_miles.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdm_miles
// Half central angle (Q30 rad) to miles (Q8), rounded half up. The divide
// by 1609 is a reciprocal multiply plus one correction step. Three stages.
// ---------------------------------------------------------------------------
module hdm_miles
  import hdm_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] angle_i,
  output logic [22:0] miles_o
);

  logic [55:0] m1;
  logic [32:0] q1_q, q1b_q, diff;
  logic [64:0] p_q;
  logic [22:0] qe;

  // Scale by 2 * 6371 km and drop the 2^22, with half of the divisor added
  assign m1 = 56'(angle_i) * 56'(MILES_K) + MILES_BIAS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q  <= m1[54:22];
      p_q   <= 65'(q1_q) * 65'(MILES_RECIP);
      q1b_q <= q1_q;
    end
  end

  // Estimate is exact or one low
  assign qe   = p_q[64:42];
  assign diff = q1b_q - 33'(qe) * MILES_DIV;

  always_ff @(posedge clk_i) begin
    if (en_i) miles_o <= qe + 23'(diff >= MILES_DIV);
  end

endmodule

@@ sv/haversine_distance_miles_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// haversine_distance_miles_unit
// Great-circle distance in miles from a stream of positions to a reference
// point held in APB registers, with a range-limit flag.
// ---------------------------------------------------------------------------
// One position enters per clock while the output is not stalled, and the
// pipeline holds one transaction per register stage in flight. The
// depth comes from two CORDIC chains (sin/cos, then asin), one stage per
// iteration, and a 31-stage square root. The whole pipeline advances as one
// whenever the output register is empty or being taken, so a stalled
// output stops the input and nothing is dropped. Registers: 0x0 reference
// latitude, 0x4 reference longitude, 0x8 range limit; write them only while
// no transaction is in flight.
module haversine_distance_miles_unit
  import hdm_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // latitude [27:0], longitude [56:28], zero pad [63:57]
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // distance_miles [21:0], zero pad [23:22]
  output logic [23:0] m_axis_tdata,
  // within_range [0]
  output logic        m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PIPE_DEPTH = 2 * CORDIC_STAGES + 47;

  localparam logic [1:0] REG_REF_LAT = 2'd0;
  localparam logic [1:0] REG_REF_LON = 2'd1;
  localparam logic [1:0] REG_MAX_DST = 2'd2;

  // Configuration registers
  logic signed [27:0] ref_lat_q;
  logic signed [28:0] ref_lon_q;
  logic [21:0]        max_dist_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_lat_q  <= 28'sd31661228;
      ref_lon_q  <= 29'(-32'sd102414312);
      max_dist_q <= 22'd25600;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_REF_LAT: ref_lat_q  <= pwdata[27:0];
        REG_REF_LON: ref_lon_q  <= pwdata[28:0];
        REG_MAX_DST: max_dist_q <= pwdata[21:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_REF_LAT: prdata = {4'b0, ref_lat_q};
      REG_REF_LON: prdata = {3'b0, ref_lon_q};
      REG_MAX_DST: prdata = {10'b0, max_dist_q};
      default:     prdata = '0;
    endcase
  end

  // Global advance: output empty or being taken
  logic en;
  logic m_valid_q;
  logic [PIPE_DEPTH-1:0] vld_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
      m_valid_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  // Input stage: angles in degrees Q21 (lat doubled, differences halved)
  logic signed [27:0]      lat;
  logic signed [28:0]      lon;
  logic signed [ANG_W-1:0] lat2_q, ref2_q, dlat_q, dlon_q;

  assign lat = s_axis_tdata[27:0];
  assign lon = s_axis_tdata[56:28];

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat2_q <= ANG_W'(lat) <<< 1;
      ref2_q <= ANG_W'(ref_lat_q) <<< 1;
      dlat_q <= ANG_W'(ref_lat_q) - ANG_W'(lat);
      dlon_q <= ANG_W'(ref_lon_q) - ANG_W'(lon);
    end
  end

  // Trig
  logic signed [31:0] cos1, cos2, u, v;

  hdm_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat (
    .clk_i(clk_i), .en_i(en), .angle_i(lat2_q), .sin_o(), .cos_o(cos1)
  );
  hdm_sincos #(.STAGES(CORDIC_STAGES)) u_sc_ref (
    .clk_i(clk_i), .en_i(en), .angle_i(ref2_q), .sin_o(), .cos_o(cos2)
  );
  hdm_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlat (
    .clk_i(clk_i), .en_i(en), .angle_i(dlat_q), .sin_o(u), .cos_o()
  );
  hdm_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
    .clk_i(clk_i), .en_i(en), .angle_i(dlon_q), .sin_o(v), .cos_o()
  );

  // Haversine term and its square roots
  logic [60:0] hav_a, hav_b;
  logic [30:0] h_root, w_root, angle;
  logic [22:0] miles;

  hdm_hav u_hav (
    .clk_i(clk_i), .en_i(en), .cos1_i(cos1), .cos2_i(cos2), .u_i(u), .v_i(v),
    .a_o(hav_a), .b_o(hav_b)
  );

  hdm_isqrt u_sqrt_h (.clk_i(clk_i), .en_i(en), .val_i(hav_a), .root_o(h_root));
  hdm_isqrt u_sqrt_w (.clk_i(clk_i), .en_i(en), .val_i(hav_b), .root_o(w_root));

  hdm_asin #(.STAGES(CORDIC_STAGES)) u_asin (
    .clk_i(clk_i), .en_i(en), .w_i(w_root), .h_i(h_root), .angle_o(angle)
  );

  hdm_miles u_miles (.clk_i(clk_i), .en_i(en), .angle_i(angle), .miles_o(miles));

  // Output register: saturate and range check
  logic [DIST_W-1:0] dist_sat;
  logic [DIST_W-1:0] dist_q;
  logic              within_q;

  assign dist_sat = miles[22] ? '1 : miles[21:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q   <= dist_sat;
      within_q <= (dist_sat <= max_dist_q);
    end
  end

  assign m_axis_tdata = {2'b00, dist_q};
  assign m_axis_tuser = within_q;

endmodule

@@ sv/hdm_port_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hdm_port_checker
// Port-level checks on the distance unit's stream behavior.
// ---------------------------------------------------------------------------
module hdm_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // Input side stalls only while a result waits unclaimed
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not track output stall");

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Distance never exceeds 12500 miles, about half the Earth's circumference
  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[21:0] <= 22'd3200000 && m_axis_tdata[23:22] == 2'b00)
    else $error("distance out of range");

  // Zero distance is always within range
  a_zero_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[21:0] == 22'd0 |-> m_axis_tuser)
    else $error("zero distance flagged out of range");

endmodule

bind haversine_distance_miles_unit hdm_port_checker u_hdm_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
